// ===== rtl/wmcc_pkg.sv =====
// Shared constants, types and codes of the windowed mean color unit.
`timescale 1ns / 1ps

package wmcc_pkg;

	parameter int MAX_DIM = 4096;
	parameter int MAX_RADIUS_DEF = 255;

	parameter int COORD_W = $clog2(MAX_DIM);
	parameter int COLOR_W = 8;
	parameter int ALPHA_W = 8;
	parameter int RADIUS_W = 8;
	parameter int STEP_W = 5;
	parameter int CFG_W = COORD_W;
	parameter int CFG_IDX_W = 2;

	parameter int SUM_W = 27;
	parameter int CNT_W = 18;
	parameter int DIV_IT_W = $clog2(SUM_W + 1);

	parameter int LUMA_W = 22;
	parameter int LUMA_WR = 2126;
	parameter int LUMA_WG = 7152;
	parameter int LUMA_WB = 722;
	parameter int HALF_LUMA = 5000 * 255;

	parameter logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(12);
	parameter logic [STEP_W-1:0] STEP_RST = STEP_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_RADIUS   = 2'd2,
		CFG_STEP     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                start;
		logic [DIV_IT_W-1:0] iters;
	} div_req_t;

endpackage

// ===== rtl/wmcc_axis.sv =====
// Window range test and grid offset for one coordinate axis.
`timescale 1ns / 1ps

module wmcc_axis import wmcc_pkg::*; #(
	parameter int RW = RADIUS_W,
	parameter int OFS_W = 9
) (
	input  logic [COORD_W-1:0] pos,
	input  logic [COORD_W-1:0] ctr,
	input  logic [RW-1:0]      rad,
	output logic               in_win,
	output logic [OFS_W-1:0]   ofs
);

	localparam int LW = ((COORD_W > RW) ? COORD_W : RW) + 1;

	logic [LW-1:0] pos_e;
	logic [LW-1:0] ctr_e;
	logic [LW-1:0] rad_e;
	logic [LW-1:0] lo;
	logic [LW-1:0] hi;
	logic [LW-1:0] diff;

	always_comb begin
		pos_e = LW'(pos);
		ctr_e = LW'(ctr);
		rad_e = LW'(rad);
		lo = (ctr_e > rad_e) ? (ctr_e - rad_e) : '0;
		hi = ctr_e + rad_e;
		in_win = (pos_e >= lo) && (pos_e <= hi);
		diff = pos_e - lo;
		ofs = diff[OFS_W-1:0];
	end

endmodule

// ===== rtl/wmcc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wmcc_div import wmcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [SUM_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	output logic             done,
	output logic [SUM_W-1:0] quo,
	output logic [CNT_W-1:0] rem
);

	logic                busy_q;
	logic                done_q;
	logic [DIV_IT_W-1:0] cnt_q;
	logic [SUM_W-1:0]    quo_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]    den_q;
	logic [CNT_W:0]      trial;
	logic [CNT_W:0]      diff;
	logic                ge;

	always_comb begin
		trial = {rem_q, quo_q[SUM_W-1]};
		ge = trial >= {1'b0, den_q};
		diff = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_IT_W'(1);
				if (cnt_q == DIV_IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_q;

endmodule

// ===== rtl/window_mean_color_contrast_pick_unit.sv =====
// Top level: windowed mean color sampler with luma based text color pick.
// Pixel occupancy: a pixel off the window ends after S_LOAD, one off the column grid after
// the column division, one past the column test after the row division too; OFS_W =
// clog2(2*MAX_RADIUS+1), 9 by default, sets both division lengths on the shared divider.
// Last pixel adds three mean divisions and the luma pass; with no sample only the luma pass.
// The result waits in an output register; the next pixel is taken meanwhile.
// Reset (arst_n low, asynchronous) clears sums, count, center color and config defaults.
`timescale 1ns / 1ps

module window_mean_color_contrast_pick_unit import wmcc_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COLOR_W-1:0]   red,
	input  logic [COLOR_W-1:0]   green,
	input  logic [COLOR_W-1:0]   blue,
	input  logic [ALPHA_W-1:0]   alpha,
	input  logic [COORD_W-1:0]   col,
	input  logic [COORD_W-1:0]   row,
	input  logic                 last_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COLOR_W-1:0]   mean_red,
	output logic [COLOR_W-1:0]   mean_green,
	output logic [COLOR_W-1:0]   mean_blue,
	output logic                 text_white,
	output logic                 used_fallback
);

	localparam int RAD_W = $clog2(MAX_RADIUS + 1);
	localparam int RW = (RAD_W > RADIUS_W) ? RAD_W : RADIUS_W;
	localparam int OFS_W = $clog2(2 * MAX_RADIUS + 1);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_LOAD = 12'b0000_0000_0010,
		S_COLM = 12'b0000_0000_0100,
		S_ROWM = 12'b0000_0000_1000,
		S_FIN  = 12'b0000_0001_0000,
		S_DR   = 12'b0000_0010_0000,
		S_DG   = 12'b0000_0100_0000,
		S_DB   = 12'b0000_1000_0000,
		S_LR   = 12'b0001_0000_0000,
		S_LG   = 12'b0010_0000_0000,
		S_LB   = 12'b0100_0000_0000,
		S_DONE = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [COORD_W-1:0]  center_x_q;
	logic [COORD_W-1:0]  center_y_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [STEP_W-1:0]   step_q;

	logic [RW-1:0]       radius_ext;
	logic [RW-1:0]       rad_sat;
	logic [STEP_W-1:0]   stp;

	logic                in_col;
	logic                in_row;
	logic [OFS_W-1:0]    ofs_col;
	logic [OFS_W-1:0]    ofs_row;
	logic                accept;

	logic [COLOR_W-1:0]  red_q;
	logic [COLOR_W-1:0]  green_q;
	logic [COLOR_W-1:0]  blue_q;
	logic                last_q;
	logic                inwin_q;
	logic [OFS_W-1:0]    ofs_col_q;
	logic [OFS_W-1:0]    ofs_row_q;

	logic [SUM_W-1:0]    sum_r_q;
	logic [SUM_W-1:0]    sum_g_q;
	logic [SUM_W-1:0]    sum_b_q;
	logic [CNT_W-1:0]    count_q;
	logic [3*COLOR_W-1:0] center_color_q;

	logic [COLOR_W-1:0]  mean_r_q;
	logic [COLOR_W-1:0]  mean_g_q;
	logic [COLOR_W-1:0]  mean_b_q;
	logic                fb_q;
	logic [LUMA_W-1:0]   luma_q;

	logic                out_valid_q;
	logic [COLOR_W-1:0]  out_r_q;
	logic [COLOR_W-1:0]  out_g_q;
	logic [COLOR_W-1:0]  out_b_q;
	logic                out_white_q;
	logic                out_fb_q;
	logic                out_free;

	div_req_t            div_req;
	logic [SUM_W-1:0]    div_num;
	logic [CNT_W-1:0]    div_den;
	logic                div_done;
	logic [SUM_W-1:0]    div_quo;
	logic [CNT_W-1:0]    div_rem;

	always_comb begin
		radius_ext = RW'(radius_q);
		rad_sat = (radius_ext > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : radius_ext;
		stp = (step_q == '0) ? STEP_W'(1) : step_q;
	end

	wmcc_axis #(.RW(RW), .OFS_W(OFS_W)) u_axis_col (
		.pos(col), .ctr(center_x_q), .rad(rad_sat), .in_win(in_col), .ofs(ofs_col)
	);

	wmcc_axis #(.RW(RW), .OFS_W(OFS_W)) u_axis_row (
		.pos(row), .ctr(center_y_q), .rad(rad_sat), .in_win(in_row), .ofs(ofs_row)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		div_req.start = 1'b0;
		div_req.iters = DIV_IT_W'(SUM_W);
		div_num = sum_r_q;
		div_den = count_q;
		case (state_q)
			S_LOAD: begin
				div_req.start = inwin_q;
				div_req.iters = DIV_IT_W'(OFS_W);
				div_num = SUM_W'(ofs_col_q) << (SUM_W - OFS_W);
				div_den = CNT_W'(stp);
			end
			S_COLM: begin
				div_req.start = div_done && (div_rem == '0);
				div_req.iters = DIV_IT_W'(OFS_W);
				div_num = SUM_W'(ofs_row_q) << (SUM_W - OFS_W);
				div_den = CNT_W'(stp);
			end
			S_FIN: begin
				div_req.start = (count_q != '0);
				div_num = sum_r_q;
			end
			S_DR: begin
				div_req.start = div_done;
				div_num = sum_g_q;
			end
			S_DG: begin
				div_req.start = div_done;
				div_num = sum_b_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	wmcc_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q <= RADIUS_RST;
			step_q <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_CENTER_X: center_x_q <= cfg_data[COORD_W-1:0];
				CFG_CENTER_Y: center_y_q <= cfg_data[COORD_W-1:0];
				CFG_RADIUS:   radius_q <= cfg_data[RADIUS_W-1:0];
				CFG_STEP:     step_q <= cfg_data[STEP_W-1:0];
				default:      radius_q <= radius_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_q <= red;
			green_q <= green;
			blue_q <= blue;
			last_q <= last_pixel;
			ofs_col_q <= ofs_col;
			ofs_row_q <= ofs_row;
			inwin_q <= (alpha != '0) && (count_q != '1) && in_col && in_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			count_q <= '0;
			center_color_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept && (col == center_x_q) && (row == center_y_q)) begin
				center_color_q <= {red, green, blue};
			end
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (inwin_q) state_q <= S_COLM;
					else state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_COLM: begin
					if (div_done) begin
						if (div_rem == '0) state_q <= S_ROWM;
						else state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_ROWM: begin
					if (div_done) begin
						if (div_rem == '0) begin
							sum_r_q <= sum_r_q + SUM_W'(red_q);
							sum_g_q <= sum_g_q + SUM_W'(green_q);
							sum_b_q <= sum_b_q + SUM_W'(blue_q);
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					state_q <= (count_q != '0) ? S_DR : S_LR;
				end
				S_DR: begin
					if (div_done) state_q <= S_DG;
				end
				S_DG: begin
					if (div_done) state_q <= S_DB;
				end
				S_DB: begin
					if (div_done) state_q <= S_LR;
				end
				S_LR: state_q <= S_LG;
				S_LG: state_q <= S_LB;
				S_LB: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						sum_r_q <= '0;
						sum_g_q <= '0;
						sum_b_q <= '0;
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_FIN: begin
				fb_q <= (count_q == '0);
				mean_r_q <= center_color_q[3*COLOR_W-1:2*COLOR_W];
				mean_g_q <= center_color_q[2*COLOR_W-1:COLOR_W];
				mean_b_q <= center_color_q[COLOR_W-1:0];
			end
			S_DR: if (div_done) mean_r_q <= div_quo[COLOR_W-1:0];
			S_DG: if (div_done) mean_g_q <= div_quo[COLOR_W-1:0];
			S_DB: if (div_done) mean_b_q <= div_quo[COLOR_W-1:0];
			S_LR: luma_q <= LUMA_W'(LUMA_WR) * LUMA_W'(mean_r_q);
			S_LG: luma_q <= luma_q + LUMA_W'(LUMA_WG) * LUMA_W'(mean_g_q);
			S_LB: luma_q <= luma_q + LUMA_W'(LUMA_WB) * LUMA_W'(mean_b_q);
			S_DONE: begin
				if (out_free) begin
					out_r_q <= mean_r_q;
					out_g_q <= mean_g_q;
					out_b_q <= mean_b_q;
					out_fb_q <= fb_q;
					out_white_q <= (luma_q < LUMA_W'(HALF_LUMA));
				end
			end
			default: luma_q <= luma_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign mean_red = out_r_q;
	assign mean_green = out_g_q;
	assign mean_blue = out_b_q;
	assign text_white = out_white_q;
	assign used_fallback = out_fb_q;

endmodule

// ===== rtl/wmcc_chk.sv =====
// Port level checker of the windowed mean color unit, bound to the top level.
`timescale 1ns / 1ps

module wmcc_chk import wmcc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [COLOR_W-1:0]   mean_red,
	input logic [COLOR_W-1:0]   mean_green,
	input logic [COLOR_W-1:0]   mean_blue,
	input logic                 text_white,
	input logic                 used_fallback
);

	int luma;

	assign luma = LUMA_WR * int'(mean_red) + LUMA_WG * int'(mean_green)
		+ LUMA_WB * int'(mean_blue);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mean_red) && $stable(mean_green)
			&& $stable(mean_blue) && $stable(text_white) && $stable(used_fallback))
		else $error("stalled result changed");

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while the first is in work");

	a_text_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_white == (luma < HALF_LUMA)))
		else $error("text color disagrees with luma of the mean color");

endmodule

bind window_mean_color_contrast_pick_unit wmcc_chk u_wmcc_chk (.*);

// ===== test/window_mean_color_contrast_pick_unit_test.sv =====
// Testbench: checks windowed mean colors and text color picks against a predictor.
`timescale 1ns / 1ps

module window_mean_color_contrast_pick_unit_test;
	import wmcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 150;
	localparam int COUNT_CAP = (1 << CNT_W) - 1;
	localparam int RANDOM_PIXELS = 560;
	localparam int PHASE_PIXELS = 45;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [ALPHA_W-1:0] alpha;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} pixel_t;

	typedef struct packed {
		logic [COLOR_W-1:0] mean_red;
		logic [COLOR_W-1:0] mean_green;
		logic [COLOR_W-1:0] mean_blue;
		logic               text_white;
		logic               used_fallback;
	} color_pick_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [COLOR_W-1:0]   red = '0;
	logic [COLOR_W-1:0]   green = '0;
	logic [COLOR_W-1:0]   blue = '0;
	logic [ALPHA_W-1:0]   alpha = '0;
	logic [COORD_W-1:0]   col = '0;
	logic [COORD_W-1:0]   row = '0;
	logic                 last_pixel = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COLOR_W-1:0]   mean_red;
	logic [COLOR_W-1:0]   mean_green;
	logic [COLOR_W-1:0]   mean_blue;
	logic                 text_white;
	logic                 used_fallback;

	logic [COORD_W-1:0]  win_cx = '0;
	logic [COORD_W-1:0]  win_cy = '0;
	logic [RADIUS_W-1:0] win_radius = RADIUS_RST;
	logic [STEP_W-1:0]   win_step = STEP_RST;
	logic [SUM_W-1:0]    red_sum = '0;
	logic [SUM_W-1:0]    green_sum = '0;
	logic [SUM_W-1:0]    blue_sum = '0;
	logic [CNT_W-1:0]    taken_count = '0;
	logic [23:0]         center_rgb = '0;

	color_pick_t expected_picks[$];
	color_pick_t want_pick;
	color_pick_t got_pick;

	int pixels_sent = 0;
	int images_sent = 0;
	int picks_checked = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int stall_sel;

	window_mean_color_contrast_pick_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.col(col),
		.row(row),
		.last_pixel(last_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mean_red(mean_red),
		.mean_green(mean_green),
		.mean_blue(mean_blue),
		.text_white(text_white),
		.used_fallback(used_fallback)
	);

	always #5 clk = ~clk;

	function automatic bit on_window_grid(int pos, int ctr, int rad, int stp);
		int lo;
		lo = (ctr > rad) ? ctr - rad : 0;
		if (pos < lo || pos > ctr + rad)
			return 1'b0;
		return ((pos - lo) % stp) == 0;
	endfunction

	function automatic int biased_pick(int lo, int hi);
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0)
			return lo;
		if (sel == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	function automatic pixel_t make_pixel(int r, int g, int b, int a, int c, int rw, bit last);
		pixel_t px;
		px.red = COLOR_W'(r);
		px.green = COLOR_W'(g);
		px.blue = COLOR_W'(b);
		px.alpha = ALPHA_W'(a);
		px.col = COORD_W'(c);
		px.row = COORD_W'(rw);
		px.last = last;
		return px;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int ctr, int rad, int stp, bit barren);
		int lo, hi, near, sel;
		lo = (ctr > rad) ? ctr - rad : 0;
		hi = ctr + rad;
		if (hi > MAX_DIM - 1)
			hi = MAX_DIM - 1;
		sel = $urandom_range(0, 9);
		if (barren || sel == 0)
			return COORD_W'($urandom_range(0, MAX_DIM - 1));
		if (sel <= 2) begin
			near = ctr + int'($urandom_range(0, 2 * rad + 8)) - rad - 4;
			if (near < 0)
				near = 0;
			if (near > MAX_DIM - 1)
				near = MAX_DIM - 1;
			return COORD_W'(near);
		end
		if (sel == 3)
			return COORD_W'(ctr);
		return COORD_W'(lo + stp * int'($urandom_range(0, (hi - lo) / stp)));
	endfunction

	task automatic absorb_pixel(input pixel_t px);
		int rad, stp, luma;
		color_pick_t pick;
		rad = (win_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : win_radius;
		stp = (win_step == 0) ? 1 : win_step;
		if (px.col == win_cx && px.row == win_cy)
			center_rgb = {px.red, px.green, px.blue};
		if (px.alpha != 0 && taken_count < COUNT_CAP &&
			on_window_grid(px.col, win_cx, rad, stp) &&
			on_window_grid(px.row, win_cy, rad, stp)) begin
			red_sum = red_sum + px.red;
			green_sum = green_sum + px.green;
			blue_sum = blue_sum + px.blue;
			taken_count = taken_count + 1'b1;
		end
		if (px.last) begin
			if (taken_count != 0) begin
				pick.mean_red = COLOR_W'(red_sum / taken_count);
				pick.mean_green = COLOR_W'(green_sum / taken_count);
				pick.mean_blue = COLOR_W'(blue_sum / taken_count);
				pick.used_fallback = 1'b0;
			end else begin
				{pick.mean_red, pick.mean_green, pick.mean_blue} = center_rgb;
				pick.used_fallback = 1'b1;
			end
			luma = LUMA_WR * int'(pick.mean_red) + LUMA_WG * int'(pick.mean_green) +
				LUMA_WB * int'(pick.mean_blue);
			pick.text_white = (luma < HALF_LUMA);
			expected_picks.push_back(pick);
			red_sum = '0;
			green_sum = '0;
			blue_sum = '0;
			taken_count = '0;
			images_sent++;
		end
	endtask

	task automatic send_pixel(input pixel_t px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
		end
		red <= px.red;
		green <= px.green;
		blue <= px.blue;
		alpha <= px.alpha;
		col <= px.col;
		row <= px.row;
		last_pixel <= px.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		absorb_pixel(px);
		burst_left--;
		pixels_sent++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_CENTER_X: win_cx = value[COORD_W-1:0];
			CFG_CENTER_Y: win_cy = value[COORD_W-1:0];
			CFG_RADIUS:   win_radius = value[RADIUS_W-1:0];
			CFG_STEP:     win_step = value[STEP_W-1:0];
			default:      ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	task automatic set_window(input int cx, input int cy, input int rad, input int stp);
		write_reg(CFG_CENTER_X, CFG_W'(cx));
		write_reg(CFG_CENTER_Y, CFG_W'(cy));
		write_reg(CFG_RADIUS, CFG_W'(rad));
		write_reg(CFG_STEP, CFG_W'(stp));
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_picks.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_window();
		logic [STEP_W-1:0] stp;
		case ($urandom_range(0, 9))
			0:       stp = '0;
			1:       stp = STEP_W'($urandom_range(17, 31));
			2:       stp = STEP_W'(16);
			default: stp = STEP_W'($urandom_range(1, 6));
		endcase
		set_window(biased_pick(0, MAX_DIM - 1), biased_pick(0, MAX_DIM - 1),
			biased_pick(0, (1 << RADIUS_W) - 1), stp);
	endtask

	task automatic send_random_image();
		int n, i, rad, stp, sel;
		bit barren;
		pixel_t px;
		rad = win_radius;
		stp = (win_step == 0) ? 1 : win_step;
		n = $urandom_range(1, 14);
		barren = ($urandom_range(0, 9) == 0);
		for (i = 0; i < n; i++) begin
			px.red = COLOR_W'(biased_pick(0, 255));
			px.green = COLOR_W'(biased_pick(0, 255));
			px.blue = COLOR_W'(biased_pick(0, 255));
			sel = $urandom_range(0, 19);
			px.alpha = (sel < 3) ? '0 : (sel < 7) ? '1 : ALPHA_W'($urandom_range(1, 255));
			px.col = pick_coord(win_cx, rad, stp, barren);
			px.row = pick_coord(win_cy, rad, stp, barren);
			if ($urandom_range(0, 9) == 0) begin
				px.col = win_cx;
				px.row = win_cy;
			end
			px.last = (i == n - 1);
			send_pixel(px);
		end
	endtask

	task automatic test_reset_defaults();
		send_pixel(make_pixel(10, 20, 30, 255, 5, 5, 1'b1));
		send_pixel(make_pixel(143, 129, 67, 0, 0, 0, 1'b0));
		send_pixel(make_pixel(255, 255, 255, 255, 1, 0, 1'b1));
		wait_idle();
	endtask

	task automatic test_far_corner();
		set_window(MAX_DIM - 1, MAX_DIM - 1, 255, 1);
		send_pixel(make_pixel(255, 255, 255, 255, 4095, 4095, 1'b0));
		send_pixel(make_pixel(0, 0, 0, 1, 3840, 3840, 1'b0));
		send_pixel(make_pixel(255, 255, 255, 255, 3839, 4000, 1'b0));
		send_pixel(make_pixel(255, 255, 255, 255, 4095, 4095, 1'b1));
		wait_idle();
	endtask

	task automatic test_single_center();
		set_window(5, 7, 0, 0);
		send_pixel(make_pixel(255, 255, 255, 255, 6, 7, 1'b0));
		send_pixel(make_pixel(143, 129, 66, 128, 5, 7, 1'b1));
		wait_idle();
	endtask

	task automatic test_origin_clip();
		set_window(2, 3, 20, 31);
		send_pixel(make_pixel(255, 0, 0, 200, 0, 0, 1'b0));
		send_pixel(make_pixel(255, 255, 255, 255, 0, 31, 1'b0));
		send_pixel(make_pixel(0, 255, 0, 255, 2, 3, 1'b0));
		send_pixel(make_pixel(0, 0, 255, 255, 0, 0, 1'b1));
		wait_idle();
	endtask

	task automatic test_pressure_pause();
		int i;
		set_window(100, 200, 9, 2);
		for (i = 0; i < 3; i++)
			send_random_image();
		hold_until_drained();
		for (i = 0; i < 3; i++)
			send_random_image();
		wait_idle();
	endtask

	task automatic test_random_windows();
		int start, phase_start;
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			random_window();
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < PHASE_PIXELS)
				send_random_image();
			wait_idle();
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_sel = $urandom_range(0, 9);
			out_stall <= (stall_sel >= 5);
			stall_left <= (stall_sel < 5) ? $urandom_range(0, 40) :
				(stall_sel < 9) ? $urandom_range(0, 5) : $urandom_range(15, 40);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_pick = {mean_red, mean_green, mean_blue, text_white, used_fallback};
			if (expected_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: red %0d green %0d blue %0d white %0d fallback %0d",
						mean_red, mean_green, mean_blue, text_white, used_fallback);
			end else begin
				want_pick = expected_picks.pop_front();
				if (got_pick !== want_pick) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch on image %0d: expected rgb %0d %0d %0d white %0d fallback %0d",
							picks_checked, want_pick.mean_red, want_pick.mean_green,
							want_pick.mean_blue, want_pick.text_white, want_pick.used_fallback);
						$display(", got rgb %0d %0d %0d white %0d fallback %0d",
							mean_red, mean_green, mean_blue, text_white, used_fallback);
					end
				end
			end
			picks_checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[window_mean_color_contrast_pick_unit] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_far_corner();
		test_single_center();
		test_origin_clip();
		test_pressure_pause();
		test_random_windows();
		$display("Covered %0d pixels in %0d images across %0d register writes; %0d results checked.",
			pixels_sent, images_sent, reg_writes, picks_checked);
		$display("Windows included the far corner, origin clipping, zero radius and odd steps; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && expected_picks.size() == 0)
			$display("[window_mean_color_contrast_pick_unit] OK");
		else
			$display("[window_mean_color_contrast_pick_unit] ERROR");
		$finish;
	end

endmodule
